// ----- rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Operation codes, character codes and reset values for the text console
// cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam logic [2:0] MODE_PUT   = 3'd0;
  localparam logic [2:0] MODE_DRAW  = 3'd1;
  localparam logic [2:0] MODE_SET   = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_HIDE  = 3'd4;
  localparam logic [2:0] MODE_SHOW  = 3'd5;
  localparam logic [2:0] MODE_CLEAR = 3'd6;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] TEXT_COLOR_RST = 8'h0F;

  typedef logic [15:0] cell_t;

endpackage

// ----- rtl/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character/attribute screen store with cursor, put byte, draw, read,
// hide/show, scroll and clear.
// ----------------------------------------------------------------------------
// Results: for most operations done is registered from the execute state,
//   which follows the accept; a new item is taken only back in idle.
// Scroll and clear sweep the store through its single read and write port,
//   then raise done from the drain state that follows the sweep.
// Reset: synchronous; after rst falls a clearing pass writes every cell to
//   zero with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [7:0]  char_byte,
  input  logic [4:0]  row,
  input  logic [6:0]  col,
  input  logic [7:0]  color,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic        cursor_hidden,
  output logic [11:0] cursor_location,
  output logic [7:0]  read_char,
  output logic        status
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELLS - SCREEN_COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          s_vld, s_vld_next;
  logic [AW-1:0] s_addr, s_addr_next;
  logic          s_blank, s_blank_next;
  logic          shift, shift_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [AW-1:0] lin, lin_next;
  logic          hidden, hidden_next;
  logic [7:0]    text_color;
  logic          res_done, res_done_next;
  logic [7:0]    res_char, res_char_next;
  logic          res_status, res_status_next;

  logic [2:0]    mode_l;
  logic [7:0]    char_l;
  logic [7:0]    color_l;
  logic [AW-1:0] tgt_l;
  logic [RW-1:0] trow_l;
  logic [CW-1:0] tcol_l;
  logic          inr_l;

  logic          in_range;
  logic [AW-1:0] tgt_in;
  logic [AW-1:0] lin_rs;
  logic          accept;

  logic          we;
  logic [AW-1:0] waddr;
  cell_t         wdata;
  logic [AW-1:0] raddr;
  cell_t         rdata;

  logic [12:0]   loc_sum;

  tcce_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign in_range = ({1'b0, row} < 6'(SCREEN_ROWS)) && ({1'b0, col} < 8'(SCREEN_COLS));
  assign tgt_in   = AW'(row[RW-1:0]) * AW'(SCREEN_COLS) + AW'(col[CW-1:0]);
  assign lin_rs   = lin - AW'(cur_col);

  always_comb begin
    logic go_sweep;
    go_sweep        = 1'b0;
    state_next      = state;
    cnt_next        = cnt;
    s_vld_next      = 1'b0;
    s_addr_next     = cnt;
    s_blank_next    = 1'b0;
    shift_next      = shift;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    lin_next        = lin;
    hidden_next     = hidden;
    res_done_next   = 1'b0;
    res_char_next   = res_char;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = lin;
    wdata           = '0;
    raddr           = tgt_in;   // read item target is issued at accept time

    case (state)
      ST_INIT: begin
        we       = 1'b1;
        waddr    = cnt;
        wdata    = '0;
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_char_next   = '0;
        res_status_next = 1'b0;
        case (mode_l)
          MODE_PUT: begin
            if (char_l == CH_NEWLINE) begin
              cur_col_next = '0;
              if (cur_row == LAST_ROW) begin
                go_sweep = 1'b1;
                lin_next = lin_rs;
              end else begin
                cur_row_next = cur_row + RW'(1);
                lin_next     = lin_rs + AW'(SCREEN_COLS);
              end
            end else if (char_l == CH_RETURN) begin
              cur_col_next = '0;
              lin_next     = lin_rs;
            end else if (char_l == CH_BACKSPACE) begin
              if (lin != '0) begin
                lin_next = lin - AW'(1);
                we       = 1'b1;
                waddr    = lin - AW'(1);
                wdata    = {text_color, CH_SPACE};
                if (cur_col == '0) begin
                  cur_col_next = LAST_COL;
                  cur_row_next = cur_row - RW'(1);
                end else begin
                  cur_col_next = cur_col - CW'(1);
                end
              end
            end else begin
              we    = 1'b1;
              waddr = lin;
              wdata = {text_color, char_l};
              if (lin == LAST_CELL) begin
                // last cell: scroll, cursor to start of last row
                go_sweep     = 1'b1;
                cur_col_next = '0;
                lin_next     = lin_rs;
              end else if (cur_col == LAST_COL) begin
                cur_col_next = '0;
                cur_row_next = cur_row + RW'(1);
                lin_next     = lin + AW'(1);
              end else begin
                cur_col_next = cur_col + CW'(1);
                lin_next     = lin + AW'(1);
              end
            end
            shift_next = 1'b1;
          end
          MODE_DRAW: begin
            if (inr_l) begin
              we    = 1'b1;
              waddr = tgt_l;
              wdata = {color_l, char_l};
            end else begin
              res_status_next = 1'b1;
            end
          end
          MODE_SET: begin
            if (inr_l) begin
              cur_row_next = trow_l;
              cur_col_next = tcol_l;
              lin_next     = tgt_l;
            end else begin
              res_status_next = 1'b1;
            end
          end
          MODE_READ: begin
            if (inr_l) begin
              res_char_next = rdata[7:0];
            end else begin
              res_status_next = 1'b1;
            end
          end
          MODE_HIDE: hidden_next = 1'b1;
          MODE_SHOW: hidden_next = 1'b0;
          MODE_CLEAR: begin
            go_sweep   = 1'b1;
            shift_next = 1'b0;
          end
          default: res_status_next = 1'b1;
        endcase
        if (go_sweep) begin
          state_next = ST_SWEEP;
          cnt_next   = '0;
        end else begin
          state_next    = ST_IDLE;
          res_done_next = 1'b1;
        end
      end

      ST_SWEEP: begin
        // read cell cnt (or the one a row below when scrolling), write back
        // the cell read in the previous cycle
        if (shift && (cnt < LAST_ROW_BASE)) begin
          raddr        = cnt + AW'(SCREEN_COLS);
          s_blank_next = 1'b0;
        end else begin
          raddr        = cnt;
          s_blank_next = 1'b1;
        end
        s_vld_next  = 1'b1;
        s_addr_next = cnt;
        if (s_vld) begin
          we    = 1'b1;
          waddr = s_addr;
          wdata = s_blank ? {rdata[15:8], CH_SPACE} : rdata;
        end
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        we              = s_vld;
        waddr           = s_addr;
        wdata           = s_blank ? {rdata[15:8], CH_SPACE} : rdata;
        res_done_next   = 1'b1;
        res_char_next   = '0;
        res_status_next = 1'b0;
        state_next      = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      s_vld      <= 1'b0;
      shift      <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      lin        <= '0;
      hidden     <= 1'b0;
      text_color <= TEXT_COLOR_RST;
      res_done   <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      s_vld    <= s_vld_next;
      shift    <= shift_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      lin      <= lin_next;
      hidden   <= hidden_next;
      res_done <= res_done_next;
      if (cfg_we) begin
        text_color <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_addr     <= s_addr_next;
    s_blank    <= s_blank_next;
    res_char   <= res_char_next;
    res_status <= res_status_next;
    if (accept) begin
      mode_l  <= mode;
      char_l  <= char_byte;
      color_l <= color;
      tgt_l   <= tgt_in;
      trow_l  <= row[RW-1:0];
      tcol_l  <= col[CW-1:0];
      inr_l   <= in_range;
    end
  end

  assign loc_sum = 13'(lin) + (hidden ? 13'(CELLS) : 13'd0);

  assign done            = res_done;
  assign cursor_row      = 5'(cur_row);
  assign cursor_col      = 7'(cur_col);
  assign cursor_hidden   = hidden;
  assign cursor_location = loc_sum[11:0];
  assign read_char       = res_char;
  assign status          = res_status;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe outside idle");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < SCREEN_ROWS) && (32'(cur_col) < SCREEN_COLS))
    else $error("cursor out of screen");

  a_lin_match: assert property (@(posedge clk) disable iff (rst)
    lin == AW'(cur_row) * AW'(SCREEN_COLS) + AW'(cur_col))
    else $error("linear cursor disagrees with row and column");

  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> !done)
    else $error("result strobe right after accept");
`endif

endmodule

// ----- rtl/tcce_ram.sv -----
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console cursor engine. A scoreboard keeps
// its own screen image, cursor and attribute register, predicts the cursor
// report for every accepted item and checks each done strobe against the
// oldest prediction. Directed items come first, then random traffic in
// three sender idling phases, with attribute register writes in between.
// ----------------------------------------------------------------------------
module testbench;
  import tcce_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLS * ROWS;
  localparam logic [2:0] MODE_BAD = 3'd7;
  localparam int PHASE_ITEMS    = 216;
  localparam int CHUNK_ITEMS    = 72;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int MAX_REPORTS    = 60;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic        hidden;
    logic [11:0] location;
    logic [7:0]  rd_char;
    logic        status;
  } cursor_report_t;

  class console_scoreboard;
    logic [15:0]    screen_cells [CELLS];
    int unsigned    cur_pos;
    bit             is_hidden;
    logic [7:0]     attr_reg;
    cursor_report_t pending_reports [$];
    int unsigned    err_count;

    function new();
      foreach (screen_cells[i]) screen_cells[i] = '0;
      cur_pos   = 0;
      is_hidden = 1'b0;
      attr_reg  = TEXT_COLOR_RST;
      err_count = 0;
    endfunction

    function void set_text_color(logic [7:0] value);
      attr_reg = value;
    endfunction

    // rows move up with their attributes; the last row keeps its attributes
    function void scroll_screen();
      for (int i = 0; i < CELLS - COLS; i++) screen_cells[i] = screen_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_cells[i][7:0] = CH_SPACE;
    endfunction

    function void print_byte(logic [7:0] ch);
      int unsigned cur_row;
      cur_row = cur_pos / COLS;
      if (ch == CH_NEWLINE) begin
        if (cur_row == ROWS - 1) scroll_screen();
        else cur_row++;
        cur_pos = cur_row * COLS;
      end else if (ch == CH_RETURN) begin
        cur_pos = cur_row * COLS;
      end else if (ch == CH_BACKSPACE) begin
        if (cur_pos != 0) begin
          cur_pos--;
          screen_cells[cur_pos] = {attr_reg, CH_SPACE};
        end
      end else begin
        screen_cells[cur_pos] = {attr_reg, ch};
        if (cur_pos == CELLS - 1) begin
          scroll_screen();
          cur_pos = (ROWS - 1) * COLS;
        end else begin
          cur_pos++;
        end
      end
    endfunction

    function void note_item(logic [2:0] op, logic [7:0] ch, logic [4:0] r, logic [6:0] c,
                            logic [7:0] attr);
      cursor_report_t rep;
      bit             fits;
      int unsigned    target;
      int unsigned    full;
      fits   = (r < ROWS) && (c < COLS);
      target = r * COLS + c;
      rep.rd_char = '0;
      rep.status  = 1'b0;
      case (op)
        MODE_PUT:   print_byte(ch);
        MODE_DRAW:  if (fits) screen_cells[target] = {attr, ch}; else rep.status = 1'b1;
        MODE_SET:   if (fits) cur_pos = target; else rep.status = 1'b1;
        MODE_READ:  if (fits) rep.rd_char = screen_cells[target][7:0]; else rep.status = 1'b1;
        MODE_HIDE:  is_hidden = 1'b1;
        MODE_SHOW:  is_hidden = 1'b0;
        MODE_CLEAR: foreach (screen_cells[i]) screen_cells[i][7:0] = CH_SPACE;
        default:    rep.status = 1'b1;
      endcase
      full       = cur_pos / COLS;
      rep.row    = full[4:0];
      full       = cur_pos % COLS;
      rep.col    = full[6:0];
      rep.hidden = is_hidden;
      full       = cur_pos + (is_hidden ? CELLS : 0);
      rep.location = full[11:0];
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(cursor_report_t got);
      cursor_report_t want;
      if (pending_reports.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: result strobe with no item pending, expected none, actual %h",
                   $time, got);
        return;
      end
      want = pending_reports.pop_front();
      compare_field("cursor_row", 32'(want.row), 32'(got.row));
      compare_field("cursor_col", 32'(want.col), 32'(got.col));
      compare_field("cursor_hidden", 32'(want.hidden), 32'(got.hidden));
      compare_field("cursor_location", 32'(want.location), 32'(got.location));
      compare_field("read_char", 32'(want.rd_char), 32'(got.rd_char));
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  mode;
  logic [7:0]  char_byte;
  logic [4:0]  row;
  logic [6:0]  col;
  logic [7:0]  color;
  logic        cfg_we;
  logic [7:0]  cfg_data;
  logic        done;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic        cursor_hidden;
  logic [11:0] cursor_location;
  logic [7:0]  read_char;
  logic        status;

  console_scoreboard sb;
  cursor_report_t    seen_report;
  int unsigned       quiet_cycles;

  text_console_cursor_engine #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .char_byte(char_byte),
    .row(row),
    .col(col),
    .color(color),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .cursor_hidden(cursor_hidden),
    .cursor_location(cursor_location),
    .read_char(read_char),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // results are checked before the item accepted at the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        seen_report.row      = cursor_row;
        seen_report.col      = cursor_col;
        seen_report.hidden   = cursor_hidden;
        seen_report.location = cursor_location;
        seen_report.rd_char  = read_char;
        seen_report.status   = status;
        sb.check_result(seen_report);
      end
      if (start === 1'b1 && busy === 1'b0) sb.note_item(mode, char_byte, row, col, color);
      if (cfg_we === 1'b1) sb.set_text_color(cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [2:0] op, logic [7:0] ch, logic [4:0] r, logic [6:0] c,
                           logic [7:0] attr);
    @(negedge clk);
    start     <= 1'b1;
    mode      <= op;
    char_byte <= ch;
    row       <= r;
    col       <= c;
    color     <= attr;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic idle_gap(int pct);
    if (pct > 0 && $urandom_range(0, 99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(0, 99) < pct) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_reports.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_text_color(logic [7:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_random();
    logic [2:0] op;
    logic [7:0] ch;
    logic [4:0] r;
    logic [6:0] c;
    logic [7:0] attr;
    int         pick;
    int         sel;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    r    = 5'($urandom_range(0, 31));
    c    = 7'($urandom_range(0, 127));
    attr = 8'($urandom_range(0, 255));
    if (pick < 55) begin
      op  = MODE_PUT;
      sel = $urandom_range(0, 99);
      if (sel < 8) ch = CH_NEWLINE;
      else if (sel < 14) ch = CH_RETURN;
      else if (sel < 22) ch = CH_BACKSPACE;
      else if (sel < 92) ch = 8'($urandom_range(32, 126));
    end else if (pick < 65) begin
      op = MODE_DRAW;
    end else if (pick < 75) begin
      op = MODE_SET;
    end else if (pick < 87) begin
      op = MODE_READ;
    end else if (pick < 91) begin
      op = MODE_HIDE;
    end else if (pick < 95) begin
      op = MODE_SHOW;
    end else if (pick < 96) begin
      op = MODE_CLEAR;
    end else begin
      op = MODE_BAD;
    end
    if ((op == MODE_DRAW || op == MODE_SET || op == MODE_READ) &&
        $urandom_range(0, 9) < 8) begin
      r = 5'($urandom_range(0, ROWS - 1));
      c = 7'($urandom_range(0, COLS - 1));
      // park the cursor near the end so printing wraps and scrolls
      if (op == MODE_SET && $urandom_range(0, 3) == 0) begin
        r = 5'(ROWS - 1);
        c = 7'($urandom_range(COLS - 8, COLS - 1));
      end
    end
    send_item(op, ch, r, c, attr);
  endtask

  initial begin
    int idle_pct [3];
    logic [7:0] next_color;
    idle_pct[0] = 6;
    idle_pct[1] = 48;
    idle_pct[2] = 0;
    rst       = 1'b1;
    start     = 1'b0;
    mode      = MODE_PUT;
    char_byte = '0;
    row       = '0;
    col       = '0;
    color     = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    sb        = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed items, attribute register at its reset value
    send_item(MODE_READ, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_PUT, 8'h41, 5'd0, 7'd0, 8'h00);
    send_item(MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0, 8'h00);
    send_item(MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0, 8'h00);
    send_item(MODE_READ, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_DRAW, 8'hFF, 5'(ROWS - 1), 7'(COLS - 1), 8'hFF);
    send_item(MODE_DRAW, 8'h55, 5'd31, 7'd127, 8'h00);
    send_item(MODE_DRAW, 8'h55, 5'(ROWS), 7'd0, 8'h12);
    send_item(MODE_DRAW, 8'h55, 5'd0, 7'(COLS), 8'h12);
    send_item(MODE_SET, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'h00);
    send_item(MODE_PUT, 8'h7E, 5'd0, 7'd0, 8'h00);
    send_item(MODE_READ, 8'h00, 5'(ROWS - 2), 7'(COLS - 1), 8'h00);
    send_item(MODE_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'h00);
    send_item(MODE_PUT, CH_NEWLINE, 5'd0, 7'd0, 8'h00);
    send_item(MODE_SET, 8'h00, 5'd3, 7'd40, 8'h00);
    send_item(MODE_PUT, CH_RETURN, 5'd0, 7'd0, 8'h00);
    send_item(MODE_PUT, CH_NEWLINE, 5'd0, 7'd0, 8'h00);
    send_item(MODE_PUT, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_SET, 8'h00, 5'd31, 7'd127, 8'h00);
    send_item(MODE_READ, 8'h00, 5'(ROWS), 7'd0, 8'h00);
    send_item(MODE_HIDE, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_HIDE, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_PUT, 8'h61, 5'd0, 7'd0, 8'h00);
    send_item(MODE_SHOW, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_SHOW, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_BAD, 8'hFF, 5'd31, 7'd127, 8'hFF);
    send_item(MODE_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00);
    send_item(MODE_READ, 8'h00, 5'd10, 7'd10, 8'h00);
    send_item(MODE_SET, 8'h00, 5'd1, 7'd0, 8'h00);
    send_item(MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0, 8'h00);

    // random traffic; the attribute register changes only while idle
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < PHASE_ITEMS / CHUNK_ITEMS; k++) begin
        if (p == 0 && k == 0) next_color = 8'h00;
        else if (p == 1 && k == 0) next_color = 8'hFF;
        else next_color = 8'($urandom_range(0, 255));
        write_text_color(next_color);
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          idle_gap(idle_pct[p]);
          send_random();
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.err_count == 0 && sb.pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.pending_reports.size() != 0)
        $display("%0t: %0d items never reported", $time, sb.pending_reports.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
